/* hw/rtl/ieu_pkg.sv */
// Package: shared constants and types for the instruction execute unit.
package ieu_pkg;
	localparam int MemBytes = 4096;
	localparam int MemAw = $clog2(MemBytes);
	localparam int NumRegs = 32;
	localparam int RegAw = 5;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_AND = 4'd1, OP_DEP = 4'd2, OP_BEQ = 4'd3, OP_BNE = 4'd4,
		OP_CLS = 4'd5, OP_LD = 4'd6, OP_RORI = 4'd7, OP_SLTI = 4'd8, OP_SSAT = 4'd9,
		OP_ST = 4'd10, OP_STP = 4'd11, OP_J = 4'd12, OP_SYS = 4'd13
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0, EV_PRINT = 2'd1, EV_MISAL = 2'd2, EV_UNKNOWN = 2'd3
	} ev_t;

	localparam logic [1:0] CFG_PRINT = 2'd0;
	localparam logic [1:0] CFG_MISAL = 2'd1;
	localparam logic [1:0] CFG_TERM = 2'd2;

	typedef struct packed {
		logic [3:0] mode;
		logic [4:0] dest_reg;
		logic [4:0] first_reg;
		logic [4:0] second_reg;
		logic signed [31:0] immediate;
	} instr_t;

	typedef struct packed {
		logic signed [31:0] pc_after;
		logic [1:0] event_kind;
		logic signed [31:0] event_value;
	} result_t;

	typedef struct packed {
		logic [1:0] index;
		logic [15:0] data;
	} cfg_t;
endpackage

/* hw/rtl/ieu_if.sv */
// Interfaces: valid/ready channels for instructions, results and configuration.
interface ieu_instr_if;
	logic valid;
	logic ready;
	ieu_pkg::instr_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ieu_result_if;
	logic valid;
	logic ready;
	ieu_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ieu_cfg_if;
	logic valid;
	logic ready;
	ieu_pkg::cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/instruction_execute_unit_core.sv */
// Execute unit for one decoded instruction against register file, data memory and PC.
// An instruction is taken in the idle state and passes through register read, execute,
// write-back and output steps, and the unit returns to idle as the result is presented.
// Deposit, sign counting, rotate and saturation with a width of 1..32 add 32 shift steps,
// one operand bit per cycle; ld and st move four bytes and an aligned stp eight, one byte
// per cycle, in a memory step. The result is held in an output register while the next
// instruction executes; that instruction stalls before its output step until the register
// is free. After reset a clearing pass zeroes the 4096-byte data memory, one byte a cycle,
// before the first instruction is taken.
module instruction_execute_unit_core (
	input logic clk,
	input logic arst_n,
	ieu_instr_if.sink in_ch,
	ieu_result_if.source out_ch,
	ieu_cfg_if.sink cfg
);
	import ieu_pkg::*;

	typedef enum logic [7:0] {
		ST_CLR = 8'b00000001, ST_IDLE = 8'b00000010, ST_RD = 8'b00000100,
		ST_EXE = 8'b00001000, ST_SER = 8'b00010000, ST_MEM = 8'b00100000,
		ST_WB = 8'b01000000, ST_OUT = 8'b10000000
	} state_t;

	state_t state_q;
	logic [31:0] rf_q [NumRegs];
	logic [7:0] mem_q [MemBytes];
	logic [MemAw-1:0] clr_q;
	logic [31:0] pc_q;
	logic [15:0] prt_q, mis_q, trm_q;
	instr_t ins_q;
	logic [31:0] a_q, b_q, d_q, acc_q, sh_q, addr_q;
	logic [5:0] cnt_q;
	logic [3:0] bcnt_q;
	logic done_q;
	logic wen_q;
	logic [RegAw-1:0] wreg_q;
	logic [7:0] rdata_q;
	logic [1:0] kind_q;
	logic [31:0] val_q;
	logic out_valid_q;
	result_t out_q;
	logic [31:0] lo_q, hi_q;

	logic in_acc;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	logic [31:0] sext_imm4;
	assign sext_imm4 = {{16{ins_q.immediate[13]}}, ins_q.immediate[13:0], 2'b00};

	logic [MemAw-1:0] maddr;
	assign maddr = addr_q[MemAw-1:0];
	logic [31:0] st_word;
	assign st_word = (bcnt_q[2]) ? d_q : b_q;
	logic [7:0] st_byte;
	always_comb begin
		case (bcnt_q[1:0])
			2'd0: st_byte = st_word[7:0];
			2'd1: st_byte = st_word[15:8];
			2'd2: st_byte = st_word[23:16];
			default: st_byte = st_word[31:24];
		endcase
	end
	logic is_store;
	assign is_store = (ins_q.mode == OP_ST) || (ins_q.mode == OP_STP);
	logic [3:0] mem_last;
	assign mem_last = (ins_q.mode == OP_STP) ? 4'd7 : 4'd3;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			mem_q[clr_q] <= 8'd0;
		end else if (state_q == ST_MEM && bcnt_q <= mem_last && is_store) begin
			mem_q[maddr] <= st_byte;
		end
		rdata_q <= mem_q[maddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			pc_q <= '0;
			prt_q <= 16'd1;
			mis_q <= 16'd2;
			trm_q <= 16'd3;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.data.index)
					CFG_PRINT: prt_q <= cfg.data.data;
					CFG_MISAL: mis_q <= cfg.data.data;
					CFG_TERM: trm_q <= cfg.data.data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						ins_q <= in_ch.data;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					a_q <= rf_q[ins_q.first_reg];
					b_q <= rf_q[ins_q.second_reg];
					d_q <= rf_q[ins_q.dest_reg];
					kind_q <= EV_NONE;
					val_q <= '0;
					wen_q <= 1'b0;
					wreg_q <= ins_q.dest_reg;
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= ST_WB;
					cnt_q <= '0;
					bcnt_q <= '0;
					acc_q <= '0;
					done_q <= 1'b0;
					addr_q <= a_q + ins_q.immediate;
					unique case (ins_q.mode)
						OP_ADD: begin acc_q <= a_q + b_q; wen_q <= 1'b1; end
						OP_AND: begin acc_q <= a_q & b_q; wen_q <= 1'b1; end
						OP_DEP: begin
							sh_q <= b_q; wreg_q <= ins_q.first_reg;
							wen_q <= 1'b1; state_q <= ST_SER;
						end
						OP_BEQ, OP_BNE: begin
							if ((a_q == b_q) == (ins_q.mode == OP_BEQ)) pc_q <= pc_q + sext_imm4;
							else pc_q <= pc_q + 32'd4;
						end
						OP_CLS, OP_RORI: begin
							sh_q <= a_q; wen_q <= 1'b1; state_q <= ST_SER;
						end
						OP_LD: begin wreg_q <= ins_q.second_reg; state_q <= ST_MEM; end
						OP_SLTI: begin
							wreg_q <= ins_q.second_reg; wen_q <= 1'b1;
							acc_q <= {31'd0, $signed(a_q) <
								$signed({{16{ins_q.immediate[15]}}, ins_q.immediate[15:0]})};
						end
						OP_SSAT: begin
							acc_q <= a_q; wen_q <= 1'b1;
							if (ins_q.immediate >= 1 && ins_q.immediate <= 32) begin
								lo_q <= 32'h8000_0000; hi_q <= 32'h7FFF_FFFF;
								sh_q <= a_q; state_q <= ST_SER;
							end
						end
						OP_ST: state_q <= ST_MEM;
						OP_STP: begin
							if (ins_q.immediate[1:0] != 2'b00) begin
								wreg_q <= 5'd8; wen_q <= 1'b1; acc_q <= {16'd0, mis_q};
							end else state_q <= ST_MEM;
						end
						OP_J: pc_q <= {pc_q[31:28], ins_q.immediate[25:0], 2'b00};
						OP_SYS: begin
							wreg_q <= 5'd8; wen_q <= 1'b1; acc_q <= {16'd0, trm_q};
							if (rf_q[8] == {16'd0, prt_q}) begin
								kind_q <= EV_PRINT; val_q <= rf_q[0];
							end else if (rf_q[8] == {16'd0, mis_q}) kind_q <= EV_MISAL;
							else begin kind_q <= EV_UNKNOWN; val_q <= rf_q[8]; end
						end
						default: ;
					endcase
				end
				ST_SER: begin
					cnt_q <= cnt_q + 1'b1;
					unique case (ins_q.mode)
						OP_DEP: begin
							if (d_q[0]) begin
								acc_q <= {sh_q[0], acc_q[31:1]};
								sh_q <= {1'b0, sh_q[31:1]};
							end else acc_q <= {1'b0, acc_q[31:1]};
							d_q <= {1'b0, d_q[31:1]};
						end
						OP_CLS: begin
							if (!done_q && sh_q[31] == a_q[31]) acc_q <= acc_q + 1'b1;
							else done_q <= 1'b1;
							sh_q <= {sh_q[30:0], 1'b0};
						end
						OP_RORI: begin
							if (cnt_q[4:0] < ins_q.immediate[4:0]) sh_q <= {sh_q[0], sh_q[31:1]};
						end
						default: begin
							if (cnt_q < 6'd32 - ins_q.immediate[5:0]) begin
								lo_q <= {lo_q[31], lo_q[31:1]};
								hi_q <= {hi_q[31], hi_q[31:1]};
							end
						end
					endcase
					if (cnt_q == 6'd31) begin
						state_q <= ST_WB;
						if (ins_q.mode == OP_RORI) acc_q <= sh_q;
						if (ins_q.mode == OP_SSAT) begin
							if ($signed(a_q) < $signed(lo_q)) acc_q <= lo_q;
							else if ($signed(a_q) > $signed(hi_q)) acc_q <= hi_q;
						end
					end
				end
				ST_MEM: begin
					bcnt_q <= bcnt_q + 1'b1;
					addr_q <= addr_q + 32'd1;
					if (bcnt_q >= 4'd1 && !is_store)
						acc_q <= {rdata_q, acc_q[31:8]};
					if (is_store && bcnt_q == mem_last) state_q <= ST_WB;
					if (!is_store && bcnt_q == 4'd4) begin
						wen_q <= 1'b1; state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wen_q) rf_q[wreg_q] <= acc_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_q <= '{pc_after: pc_q, event_kind: kind_q, event_value: val_q};
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == ST_IDLE) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q) else $error("result dropped");
	a_no_ready_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !in_ch.ready) else $error("ready during clear");
`endif
endmodule
